### src/bwm_pkg.sv
// ----------------------------------------------------------------------------
// bwm_pkg: shared types and constants for the bijective window matcher
// Table sizes, epoch width, stream widths, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bwm_pkg;

  // Table sizes are powers of two no larger than the word ID space, so a
  // table index is the low bits of the word ID.
  localparam int TARGET_IDS = 1024;
  localparam int SOURCE_IDS = 1024;
  localparam int EPOCH_BITS = 16;
  localparam int WORD_W     = 10;
  localparam int COUNT_W    = 32;

  localparam int TGT_AW    = $clog2(TARGET_IDS);
  localparam int SRC_AW    = $clog2(SOURCE_IDS);
  localparam int CLR_DEPTH = (TARGET_IDS > SOURCE_IDS) ? TARGET_IDS : SOURCE_IDS;
  localparam int CLR_AW    = $clog2(CLR_DEPTH);

  // RAM entry: {stamp, mapped word}
  localparam int ENTRY_W = EPOCH_BITS + WORD_W;

  // Stream widths, padded to whole bytes
  localparam int IN_DATA_W  = 2 * WORD_W;
  localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = 1 + 2 * COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_INIT,    // clear stamp stores after reset
    ST_IDLE,    // wait for an input word
    ST_LOOKUP,  // table read in flight
    ST_CHECK,   // compare, update tables, load result
    ST_WRAP     // epoch wrapped: clear stamp stores, then look up
  } ctrl_state_e;

  typedef struct packed {
    logic load;      // capture the input word
    logic clr_en;    // write one clear entry
    logic check_en;  // commit the check of the held word
  } bwm_cmd_t;

  typedef struct packed {
    logic wrap;       // word being offered starts a window and wraps the epoch
    logic clr_done;   // clear pointer at its last entry
    logic item_last;  // held word closes a window
    logic out_free;   // result register can take a new result
  } bwm_status_t;

endpackage

### src/bwm_ram.sv
// ----------------------------------------------------------------------------
// bwm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/bwm_ctrl.sv
// ----------------------------------------------------------------------------
// bwm_ctrl: controller for the bijective window matcher
// Sequences stamp clearing, word capture, table lookup and commit.
// ----------------------------------------------------------------------------
module bwm_ctrl import bwm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  bwm_status_t status_i,
  output bwm_cmd_t    cmd_o,
  output logic        clearing_o
);

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    clearing_o = 1'b0;
    case (state_q)
      ST_INIT, ST_WRAP: begin
        cmd_o.clr_en = 1'b1;
        clearing_o   = 1'b1;
        if (status_i.clr_done) begin
          state_d = (state_q == ST_WRAP) ? ST_LOOKUP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.wrap ? ST_WRAP : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // a closing word waits until the result register is free
        if (!status_i.item_last || status_i.out_free) begin
          cmd_o.check_en = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

### src/bwm_datapath.sv
// ----------------------------------------------------------------------------
// bwm_datapath: tables, epoch, window flag, counters and result register
// Forward and reverse maps live in RAMs with an epoch stamp per entry.
// ----------------------------------------------------------------------------
module bwm_datapath import bwm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bwm_cmd_t               cmd_i,
  output bwm_status_t            status_o,
  input  logic                   s_first_i,
  input  logic                   s_last_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                   m_tready_i,
  output logic                   m_tvalid_o,
  output logic [OUT_TDATA_W-1:0] m_tdata_o
);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Held word
  logic              last_q;
  logic [WORD_W-1:0] tgt_q, src_q;

  // Window state
  logic [EPOCH_BITS-1:0] epoch_q, epoch_inc;
  logic                  ok_q;
  logic [COUNT_W-1:0]    win_cnt_q, match_cnt_q, win_cnt_nxt, match_cnt_nxt;

  // Clear pointer
  logic [CLR_AW-1:0] clr_ptr_q;

  // Result register
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  // Table ports
  logic [ENTRY_W-1:0]    fwd_rdata, rev_rdata, fwd_wdata, rev_wdata;
  logic [EPOCH_BITS-1:0] fwd_stamp, rev_stamp;
  logic [WORD_W-1:0]     fwd_map, rev_map;
  logic                  fwd_we, rev_we, fwd_clr_ok, rev_clr_ok;
  logic [TGT_AW-1:0]     fwd_waddr;
  logic [SRC_AW-1:0]     rev_waddr;

  logic live, fhit, rhit, conflict, do_write, ok_after;

  // Conflict check on the looked-up entries
  assign fwd_stamp = fwd_rdata[ENTRY_W-1:WORD_W];
  assign fwd_map   = fwd_rdata[WORD_W-1:0];
  assign rev_stamp = rev_rdata[ENTRY_W-1:WORD_W];
  assign rev_map   = rev_rdata[WORD_W-1:0];

  assign live     = ok_q && (epoch_q != '0);
  assign fhit     = (fwd_stamp == epoch_q);
  assign rhit     = (rev_stamp == epoch_q);
  assign conflict = (fhit && (fwd_map != src_q)) || (rhit && (rev_map != tgt_q));
  assign do_write = cmd_i.check_en && live && !conflict;
  assign ok_after = ok_q && !(live && conflict);

  // Table write ports: clear sweep or map update
  assign fwd_clr_ok = ({1'b0, clr_ptr_q} < (CLR_AW + 1)'(TARGET_IDS));
  assign rev_clr_ok = ({1'b0, clr_ptr_q} < (CLR_AW + 1)'(SOURCE_IDS));
  assign fwd_we     = cmd_i.clr_en ? fwd_clr_ok : do_write;
  assign rev_we     = cmd_i.clr_en ? rev_clr_ok : do_write;
  assign fwd_waddr  = cmd_i.clr_en ? clr_ptr_q[TGT_AW-1:0] : tgt_q[TGT_AW-1:0];
  assign rev_waddr  = cmd_i.clr_en ? clr_ptr_q[SRC_AW-1:0] : src_q[SRC_AW-1:0];
  assign fwd_wdata  = cmd_i.clr_en ? '0 : {epoch_q, src_q};
  assign rev_wdata  = cmd_i.clr_en ? '0 : {epoch_q, tgt_q};

  bwm_ram #(.WIDTH(ENTRY_W), .DEPTH(TARGET_IDS)) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (fwd_we),
    .waddr_i (fwd_waddr),
    .wdata_i (fwd_wdata),
    .raddr_i (tgt_q[TGT_AW-1:0]),
    .rdata_o (fwd_rdata)
  );

  bwm_ram #(.WIDTH(ENTRY_W), .DEPTH(SOURCE_IDS)) u_rev_ram (
    .clk_i   (clk_i),
    .we_i    (rev_we),
    .waddr_i (rev_waddr),
    .wdata_i (rev_wdata),
    .raddr_i (src_q[SRC_AW-1:0]),
    .rdata_o (rev_rdata)
  );

  // Saturating counts including the closing window
  assign epoch_inc     = epoch_q + 1'b1;
  assign win_cnt_nxt   = (win_cnt_q == COUNT_MAX) ? win_cnt_q : win_cnt_q + 1'b1;
  assign match_cnt_nxt = (ok_after && (match_cnt_q != COUNT_MAX)) ?
                         match_cnt_q + 1'b1 : match_cnt_q;

  // Held word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      last_q <= s_last_i;
      tgt_q  <= s_tdata_i[WORD_W-1:0];
      src_q  <= s_tdata_i[2*WORD_W-1:WORD_W];
    end
  end

  // Epoch, window flag, counters, clear pointer, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q     <= '0;
      ok_q        <= 1'b1;
      win_cnt_q   <= '0;
      match_cnt_q <= '0;
      clr_ptr_q   <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.clr_en) begin
        clr_ptr_q <= (clr_ptr_q == CLR_AW'(CLR_DEPTH - 1)) ? '0 : clr_ptr_q + 1'b1;
      end
      if (cmd_i.load && s_first_i) begin
        epoch_q <= (epoch_inc == '0) ? EPOCH_BITS'(1) : epoch_inc;
        ok_q    <= 1'b1;
      end
      if (cmd_i.check_en) begin
        ok_q <= ok_after;
        if (last_q) begin
          win_cnt_q   <= win_cnt_nxt;
          match_cnt_q <= match_cnt_nxt;
        end
      end
      if (cmd_i.check_en && last_q) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.check_en && last_q) begin
      m_data_q <= {(OUT_TDATA_W - OUT_DATA_W)'(0), match_cnt_nxt, win_cnt_nxt, ok_after};
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  // Status to controller
  assign status_o.wrap      = s_first_i && (epoch_inc == '0);
  assign status_o.clr_done  = (clr_ptr_q == CLR_AW'(CLR_DEPTH - 1));
  assign status_o.item_last = last_q;
  assign status_o.out_free  = !m_valid_q || m_tready_i;

endmodule

### src/bijective_window_match.sv
// ----------------------------------------------------------------------------
// bijective_window_match: one-to-one substitution check over word windows
// Checks each (target, source) word pair against epoch-stamped forward and
// reverse maps and reports match flag and saturating counts per window.
// ----------------------------------------------------------------------------
// Channel   Dir  Content
// s_axis    in   tdata {source_word[19:10], target_word[9:0]}, tuser first, tlast last
// m_axis    out  tdata {matches_seen[64:33], windows_seen[32:1], window_matches[0]}
//
// Each input word passes capture, RAM read and check/update before the next
// is taken: the registered read of the map RAMs sits in the loop between words.
// After reset the stamp RAMs are swept to zero while no word is accepted.
// A window start that wraps the epoch sweeps them again before its lookup.
// The result sits in an output register; a closing word waits in its check
// cycle only while the previous result is still not taken.
// ----------------------------------------------------------------------------
module bijective_window_match import bwm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // target_word, source_word, pad
  input  logic                   s_axis_tuser_i,   // first_of_window
  input  logic                   s_axis_tlast_i,   // last_of_window
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o    // window_matches, windows_seen,
                                                   // matches_seen, pad
);

  bwm_cmd_t    cmd;
  bwm_status_t status;
  logic        clearing;

  bwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .clearing_o (clearing)
  );

  bwm_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .s_first_i  (s_axis_tuser_i),
    .s_last_i   (s_axis_tlast_i),
    .s_tdata_i  (s_axis_tdata_i),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o)
  );

  // No word is taken during a clear sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s_axis_tready_o)
    else $error("word accepted during stamp clear");

  // Capture and commit never coincide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load && cmd.check_en))
    else $error("load and check in the same cycle");

  // A result never overwrites one that is still pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.check_en && status.item_last) |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("pending result overwritten");

  // Match count never exceeds window count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[64:33] <= m_axis_tdata_o[32:1]))
    else $error("matches_seen above windows_seen");

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bijective_window_match
// Streams (target, source) word pairs into the matcher and checks each
// window result (match flag, window count, match count) against a local
// model of the epoch-stamped forward and reverse maps. A directed table
// covers the corner cases. Random well-formed windows follow, with some
// noise and random idling on both sides.
// ----------------------------------------------------------------------------
module testbench import bwm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 4000;  // idle cycles before the watchdog fires
  localparam int HOLD_AT      = 30;    // result index at which the sink holds off
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int RAND_A_PAIRS = 200;
  localparam int RAND_B_PAIRS = 250;
  localparam int DIR_ROWS     = 20;
  localparam logic [EPOCH_BITS-1:0] EPOCH_TOP = '1;
  localparam logic [COUNT_W-1:0]    COUNT_TOP = '1;

  typedef struct packed {
    logic              first;
    logic              last;
    logic [WORD_W-1:0] target;
    logic [WORD_W-1:0] source;
  } pair_t;

  typedef struct packed {
    logic               match;
    logic [COUNT_W-1:0] windows;
    logic [COUNT_W-1:0] hits;
  } window_res_t;

  // one directed row; typed marks rows whose result is written out here
  typedef struct packed {
    logic               first;
    logic               last;
    logic [WORD_W-1:0]  target;
    logic [WORD_W-1:0]  source;
    logic               typed;
    logic               match;
    logic [COUNT_W-1:0] windows;
    logic [COUNT_W-1:0] hits;
  } dir_row_t;

  typedef enum int {
    WIN_CONSISTENT,  // one fixed bijection over a small word range
    WIN_CLASH,       // tiny word pool, conflicts likely
    WIN_BROKEN       // consistent content, flags and one word disturbed
  } win_kind_e;

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // pair before any window start: epoch still zero
    '{1'b0, 1'b1, 10'd5,    10'd7,    1'b1, 1'b1, 32'd1,  32'd1},
    // consistent window, word extremes
    '{1'b1, 1'b0, 10'd0,    10'd0,    1'b0, 1'b0, 32'd0,  32'd0},
    '{1'b0, 1'b0, 10'd1023, 10'd1023, 1'b0, 1'b0, 32'd0,  32'd0},
    '{1'b0, 1'b1, 10'd0,    10'd0,    1'b1, 1'b1, 32'd2,  32'd2},
    // forward conflict
    '{1'b1, 1'b0, 10'd1,    10'd2,    1'b0, 1'b0, 32'd0,  32'd0},
    '{1'b0, 1'b1, 10'd1,    10'd3,    1'b1, 1'b0, 32'd3,  32'd2},
    // reverse conflict
    '{1'b1, 1'b0, 10'd1,    10'd2,    1'b0, 1'b0, 32'd0,  32'd0},
    '{1'b0, 1'b1, 10'd4,    10'd2,    1'b1, 1'b0, 32'd4,  32'd2},
    // first and last on one pair
    '{1'b1, 1'b1, 10'd10,   10'd20,   1'b1, 1'b1, 32'd5,  32'd3},
    // pairs after a last flag stay in the same epoch
    '{1'b0, 1'b1, 10'd10,   10'd21,   1'b1, 1'b0, 32'd6,  32'd3},
    '{1'b0, 1'b1, 10'd30,   10'd30,   1'b1, 1'b0, 32'd7,  32'd3},
    // pairs after a conflict are ignored
    '{1'b1, 1'b0, 10'd5,    10'd5,    1'b0, 1'b0, 32'd0,  32'd0},
    '{1'b0, 1'b0, 10'd6,    10'd6,    1'b0, 1'b0, 32'd0,  32'd0},
    '{1'b0, 1'b0, 10'd5,    10'd9,    1'b0, 1'b0, 32'd0,  32'd0},
    '{1'b0, 1'b0, 10'd7,    10'd7,    1'b0, 1'b0, 32'd0,  32'd0},
    '{1'b0, 1'b1, 10'd7,    10'd8,    1'b1, 1'b0, 32'd8,  32'd3},
    // stale mappings from an older epoch must not hit
    '{1'b1, 1'b0, 10'd1023, 10'd0,    1'b0, 1'b0, 32'd0,  32'd0},
    '{1'b0, 1'b0, 10'd0,    10'd1023, 1'b0, 1'b0, 32'd0,  32'd0},
    '{1'b0, 1'b1, 10'd1023, 10'd0,    1'b1, 1'b1, 32'd9,  32'd4},
    '{1'b1, 1'b1, 10'd512,  10'd512,  1'b1, 1'b1, 32'd10, 32'd5}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // model state
  logic [WORD_W-1:0]     fwd_map   [TARGET_IDS];
  logic [EPOCH_BITS-1:0] fwd_stamp [TARGET_IDS];
  logic [WORD_W-1:0]     rev_map   [SOURCE_IDS];
  logic [EPOCH_BITS-1:0] rev_stamp [SOURCE_IDS];
  logic [EPOCH_BITS-1:0] epoch      = '0;
  logic                  window_ok  = 1'b1;
  logic [COUNT_W-1:0]    win_count  = '0;
  logic [COUNT_W-1:0]    hit_count  = '0;

  window_res_t pending_windows[$];
  int          errors        = 0;
  int          pairs_sent    = 0;
  int          results_taken = 0;
  int          quiet_cycles  = 0;
  bit          steady        = 1'b0;  // no random idling on either side while set

  bijective_window_match i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    foreach (fwd_stamp[i]) fwd_stamp[i] = '0;
    foreach (rev_stamp[i]) rev_stamp[i] = '0;
  end

  // Advance the map model by one pair; returns 1 when the pair closes a window
  function automatic bit window_step(input pair_t p, output window_res_t r);
    int  ti;
    int  si;
    bit  fhit;
    bit  rhit;
    r  = '0;
    ti = int'(p.target) % TARGET_IDS;
    si = int'(p.source) % SOURCE_IDS;
    if (p.first) begin
      if (epoch == EPOCH_TOP) begin
        foreach (fwd_stamp[i]) fwd_stamp[i] = '0;
        foreach (rev_stamp[i]) rev_stamp[i] = '0;
        epoch = EPOCH_BITS'(1);
      end else begin
        epoch = epoch + 1'b1;
      end
      window_ok = 1'b1;
    end
    if (window_ok && epoch != '0) begin
      fhit = (fwd_stamp[ti] == epoch);
      rhit = (rev_stamp[si] == epoch);
      if ((fhit && fwd_map[ti] != p.source) || (rhit && rev_map[si] != p.target)) begin
        window_ok = 1'b0;
      end else begin
        fwd_stamp[ti] = epoch;
        fwd_map[ti]   = p.source;
        rev_stamp[si] = epoch;
        rev_map[si]   = p.target;
      end
    end
    if (!p.last) return 1'b0;
    if (win_count != COUNT_TOP) win_count = win_count + 1'b1;
    if (window_ok && hit_count != COUNT_TOP) hit_count = hit_count + 1'b1;
    r.match   = window_ok;
    r.windows = win_count;
    r.hits    = hit_count;
    return 1'b1;
  endfunction

  function automatic int idle_cycles();
    return steady ? 0 : $urandom_range(0, 5);
  endfunction

  // Offer one pair, wait for the handshake, then record what it should produce
  task automatic offer_pair(input pair_t p, input bit typed, input window_res_t typed_res);
    int          gap;
    window_res_t res;
    gap = idle_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({p.source, p.target});
    s_axis_tuser  <= p.first;
    s_axis_tlast  <= p.last;
    do @(posedge clk_i); while (!s_axis_tready);
    pairs_sent++;
    if (window_step(p, res)) pending_windows.push_back(typed ? typed_res : res);
  endtask

  // One random window, or now and then a single stray pair
  task automatic offer_window();
    int          len;
    win_kind_e   kind;
    logic [9:0]  key;
    logic [9:0]  base;
    pair_t       p;
    len  = $urandom_range(1, 8);
    kind = win_kind_e'($urandom_range(0, 2));
    key  = 10'($urandom);
    base = 10'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      p.first  = 1'($urandom);
      p.last   = 1'($urandom);
      p.target = 10'($urandom);
      p.source = 10'($urandom);
      offer_pair(p, 1'b0, '0);
      return;
    end
    for (int i = 0; i < len; i++) begin
      p.first = (i == 0);
      p.last  = (i == len - 1);
      case (kind)
        WIN_CLASH: begin
          p.target = 10'($urandom_range(0, 7));
          p.source = 10'($urandom_range(0, 7));
        end
        default: begin
          p.target = base + 10'($urandom_range(0, 5));
          p.source = p.target ^ key;
        end
      endcase
      if (kind == WIN_BROKEN) begin
        if ($urandom_range(0, 3) == 0) p.source = p.source ^ (10'd1 << $urandom_range(0, 9));
        if ($urandom_range(0, 5) == 0) p.first = ~p.first;
        if ($urandom_range(0, 5) == 0) p.last  = ~p.last;
      end
      offer_pair(p, 1'b0, '0);
    end
  endtask

  task automatic random_windows(input int count);
    int goal;
    int stretch;
    goal    = pairs_sent + count;
    stretch = pairs_sent;
    while (pairs_sent < goal) begin
      // switch between idling and back-to-back stretches
      if (pairs_sent - stretch >= 60) begin
        stretch = pairs_sent;
        steady  = ($urandom_range(0, 3) == 0);
      end
      offer_window();
    end
    steady = 1'b0;
  endtask

  // Result sink: random stalls, one long hold-off, field-by-field check
  initial begin
    window_res_t want;
    window_res_t got;
    int          gap;
    wait (rst_n);
    @(posedge clk_i);
    forever begin
      gap = (results_taken == HOLD_AT) ? HOLD_CYCLES : idle_cycles();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      results_taken++;
      got.match   = m_axis_tdata[0];
      got.windows = m_axis_tdata[COUNT_W:1];
      got.hits    = m_axis_tdata[2*COUNT_W:COUNT_W+1];
      if (pending_windows.size() == 0) begin
        $display("%0t: unexpected result match=%0b windows=%0d matches=%0d",
                 $time, got.match, got.windows, got.hits);
        errors++;
      end else begin
        want = pending_windows.pop_front();
        if (got.match !== want.match) begin
          $display("%0t: window_matches expected %0b actual %0b", $time, want.match, got.match);
          errors++;
        end
        if (got.windows !== want.windows) begin
          $display("%0t: windows_seen expected %0d actual %0d",
                   $time, want.windows, got.windows);
          errors++;
        end
        if (got.hits !== want.hits) begin
          $display("%0t: matches_seen expected %0d actual %0d",
                   $time, want.hits, got.hits);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    pair_t       p;
    window_res_t r;
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;

    // directed corner cases
    foreach (DIR_TABLE[k]) begin
      p.first   = DIR_TABLE[k].first;
      p.last    = DIR_TABLE[k].last;
      p.target  = DIR_TABLE[k].target;
      p.source  = DIR_TABLE[k].source;
      r.match   = DIR_TABLE[k].match;
      r.windows = DIR_TABLE[k].windows;
      r.hits    = DIR_TABLE[k].hits;
      offer_pair(p, DIR_TABLE[k].typed, r);
    end

    // random windows, the sink's long hold-off lands in here
    random_windows(RAND_A_PAIRS);

    // more random windows
    random_windows(RAND_B_PAIRS);
    s_axis_tvalid <= 1'b0;

    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### bijective_window_match.f
src/bwm_pkg.sv
src/bwm_ram.sv
src/bwm_ctrl.sv
src/bwm_datapath.sv
src/bijective_window_match.sv
bench/testbench.sv
